@@ rtl/source_token_scanner_defines.svh @@
// ---------------------------------------------------------------------------
// source_token_scanner_defines.svh
// assertion macros shared by the scanner rtl
// ---------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_SCANNER_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_DEFINES_SVH

// check that a condition implies a consequence on the same edge
`define STS_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// check that a condition implies a consequence on the next edge
`define STS_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sts_pkg.sv @@
// ---------------------------------------------------------------------------
// sts_pkg
// types, token codes and character classes for the source token scanner
// ---------------------------------------------------------------------------
package sts_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int FIELD_W           = 16;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_IDENT    = 3'd1,
        MODE_NUMBER   = 3'd2,
        MODE_STRING   = 3'd3,
        MODE_COMMENT  = 3'd4,
        MODE_OPERATOR = 3'd5
    } scan_mode_t;

    localparam logic [5:0] KIND_IDENT  = 6'd16;
    localparam logic [5:0] KIND_NUMBER = 6'd17;
    localparam logic [5:0] KIND_STRING = 6'd18;
    localparam logic [5:0] KIND_EOF    = 6'd43;
    localparam logic [5:0] KIND_ERROR  = 6'd44;
    localparam logic [5:0] KIND_NONE   = 6'd0;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_UNTERM     = 2'd2;

    localparam int KW_COUNT = 16;
    localparam logic [63:0] KW_TABLE [KW_COUNT] = '{
        64'h666E, 64'h6C6574, 64'h6C6F6F70, 64'h6C6F63616C,
        64'h676C6F62616C, 64'h7072696E74, 64'h6966, 64'h656C7365,
        64'h65786974, 64'h72657475726E, 64'h636F6E7374, 64'h636C617373,
        64'h737769746368, 64'h63617365, 64'h627265616B, 64'h74686973
    };

    typedef struct packed {
        logic [5:0]         kind;
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] column;
        logic [1:0]         err;
    } token_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [5:0] single_punct(input logic [7:0] c);
        case (c)
            8'h28: return 6'd19;
            8'h29: return 6'd20;
            8'h7B: return 6'd21;
            8'h7D: return 6'd22;
            8'h5B: return 6'd23;
            8'h5D: return 6'd24;
            8'h2C: return 6'd25;
            8'h2A: return 6'd26;
            8'h2F: return 6'd27;
            8'h3A: return 6'd40;
            8'h3B: return 6'd41;
            8'h2E: return 6'd42;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic logic [5:0] operator_base(input logic [7:0] c);
        case (c)
            8'h2D: return 6'd28;
            8'h2B: return 6'd30;
            8'h3D: return 6'd32;
            8'h21: return 6'd34;
            8'h3C: return 6'd36;
            8'h3E: return 6'd38;
            default: return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] operator_second(input logic [7:0] c);
        if (c == 8'h2D || c == 8'h2B)
            return c;
        return 8'h3D;
    endfunction

endpackage

@@ rtl/source_token_scanner.sv @@
// ---------------------------------------------------------------------------
// source_token_scanner
// streaming lexer: one source byte in, up to two tokens out
// ---------------------------------------------------------------------------
//  channel | signals                                         | dir
//  input   | in_valid in_ready source_byte end_of_source     | in
//  output  | out_valid out_ready token_kind .. last_of_run   | out
//
//  each byte is scanned combinationally; its tokens show at the outputs the next cycle
//  a byte that closes a pending token and is itself a one-byte token, and an
//  end of source with a token open, give two tokens, which leave one after the other
//  input is taken whenever the two-entry buffer will be empty after this cycle
//  reset clears scan state and counters to line 1, column 1, offset 0.
`include "source_token_scanner_defines.svh"

module source_token_scanner #(
    parameter int POSITION_BITS = sts_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 source_byte,
    input  logic                       end_of_source,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [5:0]                 token_kind,
    output logic [sts_pkg::FIELD_W-1:0] start_offset,
    output logic [sts_pkg::FIELD_W-1:0] token_length,
    output logic [sts_pkg::FIELD_W-1:0] start_line,
    output logic [sts_pkg::FIELD_W-1:0] start_column,
    output logic [1:0]                 error_code,
    output logic                       last_of_run
);

    localparam int FW   = sts_pkg::FIELD_W;
    localparam int WINW = 8 * KEYWORD_CHARS;
    localparam int PB   = POSITION_BITS;
    localparam logic [PB-1:0] LIM_P = (PB < FW) ? {PB{1'b1}} : PB'(16'hFFFF);
    localparam logic [FW-1:0] LEN_MAX = {FW{1'b1}};

    // scan state
    sts_pkg::scan_mode_t mode_reg, mode_next;
    logic [7:0]      pend_reg, pend_next;
    logic [WINW-1:0] win_reg, win_next;
    logic [PB-1:0]   toff_reg, toff_next, pos_reg, pos_next;
    logic [PB-1:0]   tline_reg, tline_next, tcol_reg, tcol_next;
    logic [PB-1:0]   line_reg, line_next, col_reg, col_next;
    logic [FW-1:0]   len_reg, len_next;

    // output buffer: two slots, fifo order
    sts_pkg::token_t buf_reg [2];
    logic            blast_reg [2];
    logic [1:0]      cnt_reg, cnt_next;
    logic            rd_reg;

    sts_pkg::token_t tok_a, tok_b, tok_open, tok_here;
    logic            emit_a, emit_b;
    logic [5:0]      kw_kind;
    logic            accept, pop;
    logic [7:0]      c;
    logic [FW-1:0]   len_grow;

    assign c        = source_byte;
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid && out_ready;
    assign in_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign len_grow = (len_reg == LEN_MAX) ? len_reg : len_reg + FW'(1);

    // keyword match over the window
    always_comb
    begin
        kw_kind = sts_pkg::KIND_IDENT;
        if (len_reg <= FW'(KEYWORD_CHARS))
        begin
            for (int i = sts_pkg::KW_COUNT - 1; i >= 0; i--)
            begin
                if (64'(win_reg) == sts_pkg::KW_TABLE[i])
                    kw_kind = 6'(i);
            end
        end
    end

    // token descriptors for the open token and for the current byte
    always_comb
    begin
        tok_open.kind   = sts_pkg::KIND_NONE;
        tok_open.offset = FW'(toff_reg);
        tok_open.length = len_reg;
        tok_open.line   = FW'(tline_reg);
        tok_open.column = FW'(tcol_reg);
        tok_open.err    = sts_pkg::ERR_NONE;
        tok_here.kind   = sts_pkg::KIND_NONE;
        tok_here.offset = FW'(pos_reg);
        tok_here.length = FW'(1);
        tok_here.line   = FW'(line_reg);
        tok_here.column = FW'(col_reg);
        tok_here.err    = sts_pkg::ERR_NONE;
    end

    // one scan step
    always_comb
    begin
        logic scan_byte;
        logic [5:0] pk;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        win_next   = win_reg;
        toff_next  = toff_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        len_next   = len_reg;
        pos_next   = pos_reg + PB'(1);
        line_next  = line_reg;
        col_next   = (col_reg < LIM_P) ? col_reg + PB'(1) : col_reg;
        pk         = sts_pkg::single_punct(c);
        if (c == 8'h0A)
        begin
            line_next = (line_reg < LIM_P) ? line_reg + PB'(1) : line_reg;
            col_next  = PB'(1);
        end
        emit_a    = 1'b0;
        emit_b    = 1'b0;
        tok_a     = tok_open;
        tok_b     = tok_here;
        scan_byte = 1'b0;
        if (end_of_source)
        begin
            tok_b        = tok_here;
            tok_b.kind   = sts_pkg::KIND_EOF;
            tok_b.length = '0;
            emit_b       = 1'b1;
            emit_a       = 1'b1;
            case (mode_reg)
                sts_pkg::MODE_IDENT:    tok_a.kind = kw_kind;
                sts_pkg::MODE_NUMBER:   tok_a.kind = sts_pkg::KIND_NUMBER;
                sts_pkg::MODE_STRING:
                begin
                    tok_a.kind = sts_pkg::KIND_ERROR;
                    tok_a.err  = sts_pkg::ERR_UNTERM;
                end
                sts_pkg::MODE_OPERATOR: tok_a.kind = sts_pkg::operator_base(pend_reg);
                default:                emit_a = 1'b0;
            endcase
            mode_next  = sts_pkg::MODE_IDLE;
            pend_next  = '0;
            win_next   = '0;
            toff_next  = '0;
            tline_next = PB'(1);
            tcol_next  = PB'(1);
            len_next   = '0;
            pos_next   = '0;
            line_next  = PB'(1);
            col_next   = PB'(1);
        end
        else
        begin
            case (mode_reg)
                sts_pkg::MODE_IDENT:
                begin
                    if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c))
                    begin
                        if (len_reg < FW'(KEYWORD_CHARS))
                            win_next = {win_reg[WINW-9:0], c};
                        len_next = len_grow;
                    end
                    else
                    begin
                        tok_a.kind = kw_kind;
                        emit_a     = 1'b1;
                        scan_byte  = 1'b1;
                    end
                end
                sts_pkg::MODE_NUMBER:
                begin
                    if (sts_pkg::is_digit(c))
                        len_next = len_grow;
                    else
                    begin
                        tok_a.kind = sts_pkg::KIND_NUMBER;
                        emit_a     = 1'b1;
                        scan_byte  = 1'b1;
                    end
                end
                sts_pkg::MODE_STRING:
                begin
                    len_next = len_grow;
                    if (c == 8'h22)
                    begin
                        tok_b        = tok_open;
                        tok_b.length = len_grow;
                        tok_b.kind   = sts_pkg::KIND_STRING;
                        emit_b       = 1'b1;
                        mode_next    = sts_pkg::MODE_IDLE;
                    end
                end
                sts_pkg::MODE_COMMENT:
                begin
                    if (c == 8'h0A)
                        mode_next = sts_pkg::MODE_IDLE;
                end
                sts_pkg::MODE_OPERATOR:
                begin
                    pend_next = '0;
                    mode_next = sts_pkg::MODE_IDLE;
                    if (c == sts_pkg::operator_second(pend_reg))
                    begin
                        tok_b        = tok_open;
                        tok_b.length = len_grow;
                        tok_b.kind   = sts_pkg::operator_base(pend_reg) + 6'd1;
                        emit_b       = 1'b1;
                        len_next     = len_grow;
                    end
                    else
                    begin
                        tok_a.kind = sts_pkg::operator_base(pend_reg);
                        emit_a     = 1'b1;
                        scan_byte  = 1'b1;
                    end
                end
                default: scan_byte = 1'b1;
            endcase
            // idle scan of the current byte
            if (scan_byte)
            begin
                mode_next = sts_pkg::MODE_IDLE;
                if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A)
                begin
                end
                else if (c == 8'h23)
                    mode_next = sts_pkg::MODE_COMMENT;
                else if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c) || c == 8'h22
                         || sts_pkg::operator_base(c) != sts_pkg::KIND_NONE)
                begin
                    toff_next  = pos_reg;
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                    len_next   = FW'(1);
                    if (sts_pkg::is_alpha(c))
                    begin
                        mode_next = sts_pkg::MODE_IDENT;
                        win_next  = WINW'(c);
                    end
                    else if (sts_pkg::is_digit(c))
                        mode_next = sts_pkg::MODE_NUMBER;
                    else if (c == 8'h22)
                        mode_next = sts_pkg::MODE_STRING;
                    else
                    begin
                        mode_next = sts_pkg::MODE_OPERATOR;
                        pend_next = c;
                    end
                end
                else
                begin
                    emit_b = 1'b1;
                    if (pk != sts_pkg::KIND_NONE)
                        tok_b.kind = pk;
                    else
                    begin
                        tok_b.kind = sts_pkg::KIND_ERROR;
                        tok_b.err  = sts_pkg::ERR_UNEXPECTED;
                    end
                end
            end
        end
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sts_pkg::MODE_IDLE;
            pend_reg  <= '0;
            win_reg   <= '0;
            toff_reg  <= '0;
            tline_reg <= PB'(1);
            tcol_reg  <= PB'(1);
            len_reg   <= '0;
            pos_reg   <= '0;
            line_reg  <= PB'(1);
            col_reg   <= PB'(1);
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            win_reg   <= win_next;
            toff_reg  <= toff_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

    // output buffer control
    always_comb
    begin
        cnt_next = cnt_reg - {1'b0, pop};
        if (accept)
            cnt_next = cnt_next + {1'b0, emit_a} + {1'b0, emit_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (pop)
                rd_reg <= ~rd_reg;
        end
    end

    // output buffer payload, write pointer follows read pointer and count
    always_ff @(posedge clk)
    begin
        logic wp;
        wp = rd_reg ^ pop ^ (cnt_reg[0] ^ pop);
        if (accept)
        begin
            // the first token is the last of its item when no second one follows
            if (emit_a)
            begin
                buf_reg[wp]   <= tok_a;
                blast_reg[wp] <= ~emit_b;
                wp = ~wp;
            end
            if (emit_b)
            begin
                buf_reg[wp]   <= tok_b;
                blast_reg[wp] <= 1'b1;
            end
        end
    end

    assign out_valid    = cnt_reg != 2'd0;
    assign token_kind   = buf_reg[rd_reg].kind;
    assign start_offset = buf_reg[rd_reg].offset;
    assign token_length = buf_reg[rd_reg].length;
    assign start_line   = buf_reg[rd_reg].line;
    assign start_column = buf_reg[rd_reg].column;
    assign error_code   = buf_reg[rd_reg].err;
    assign last_of_run  = blast_reg[rd_reg];

    // checks
    `STS_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg != 2'd3, "buffer count overflow")
    `STS_ASSERT_IMPL(a_ready_room, accept, cnt_reg - {1'b0, pop} == 2'd0, "accept without room")
    `STS_ASSERT_NEXT(a_eos_reset, accept && end_of_source, pos_reg == '0 && line_reg == PB'(1),
        "end of source did not reset position")

endmodule
